// ----- hw/rtl/plane_shape_signed_distance_macros.svh -----
// Assertion macros for the plane signed-distance block.
`ifndef PLANE_SHAPE_SIGNED_DISTANCE_MACROS_SVH
`define PLANE_SHAPE_SIGNED_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define PSD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PSD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/psd_pkg.sv -----
// Types and constants for the plane signed-distance block.
package psd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int STAGES    = 6;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_NORMAL_X     = 2'd0;
   localparam logic [1:0] REG_NORMAL_Y     = 2'd1;
   localparam logic [1:0] REG_NORMAL_Z     = 2'd2;
   localparam logic [1:0] REG_PLANE_OFFSET = 2'd3;

   typedef enum logic [1:0] {
      MODE_SEGMENT = 2'd0,
      MODE_RAY     = 2'd1,
      MODE_SPHERE  = 2'd2,
      MODE_BOX     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SIDE_CROSS    = 2'd0,
      SIDE_POSITIVE = 2'd1,
      SIDE_NEGATIVE = 2'd2
   } side_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] point_a_x;
      logic signed [31:0] point_a_y;
      logic signed [31:0] point_a_z;
      logic signed [31:0] point_b_x;
      logic signed [31:0] point_b_y;
      logic signed [31:0] point_b_z;
      logic [30:0]        radius;
   } req_type;

   typedef struct packed {
      logic signed [31:0] distance;
      logic [1:0]         side;
   } rsp_type;

endpackage

// ----- hw/rtl/plane_shape_signed_distance.sv -----
// Plane versus shape signed distance: six-stage pipeline with register port.
// Throughput: one transaction per cycle in every stage while rsp_ready stays high.
// A stalled rsp holds the whole pipe only where every stage is full.
// Reset (synchronous, active high) empties all stages and zeroes the plane.
`include "plane_shape_signed_distance_macros.svh"

module plane_shape_signed_distance (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  psd_pkg::req_type                    req_payload,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output psd_pkg::rsp_type                    rsp_payload,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [psd_pkg::ADDR_W-1:0]          paddr,
   input  logic [psd_pkg::DATA_W-1:0]          pwdata,
   output logic [psd_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);

   // ------------------------------------------------------------------
   // Plane registers. The user must write them only while the pipe is empty; the block does not enforce this.
   // ------------------------------------------------------------------
   logic signed [31:0] nx_ff, ny_ff, nz_ff, off_ff;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= '0;
         ny_ff  <= '0;
         nz_ff  <= '0;
         off_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            psd_pkg::REG_NORMAL_X:     nx_ff  <= pwdata;
            psd_pkg::REG_NORMAL_Y:     ny_ff  <= pwdata;
            psd_pkg::REG_NORMAL_Z:     nz_ff  <= pwdata;
            psd_pkg::REG_PLANE_OFFSET: off_ff <= pwdata;
            default:                   nx_ff  <= nx_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         psd_pkg::REG_NORMAL_X:     prdata = nx_ff;
         psd_pkg::REG_NORMAL_Y:     prdata = ny_ff;
         psd_pkg::REG_NORMAL_Z:     prdata = nz_ff;
         psd_pkg::REG_PLANE_OFFSET: prdata = off_ff;
         default:                   prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage advances when it is empty or when
   // the stage after it advances; the output stage advances when empty
   // or when the result transaction is taken.
   // ------------------------------------------------------------------
   logic [psd_pkg::STAGES-1:0] vld_ff, vld_in, adv;

   always_comb begin
      adv[psd_pkg::STAGES-1] = !vld_ff[psd_pkg::STAGES-1] || rsp_ready;
      for (int k = psd_pkg::STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = req_valid;
      for (int k = 1; k < psd_pkg::STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < psd_pkg::STAGES; k++) begin
            if (adv[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: pick the two points to project. Segment and ray use the
   // origin and the direction; a box uses its near and far corners,
   // chosen per axis by the sign of the normal component.
   // ------------------------------------------------------------------
   logic signed [31:0] s1_p_in [3];
   logic signed [31:0] s1_q_in [3];
   logic signed [31:0] s1_p_ff [3];
   logic signed [31:0] s1_q_ff [3];
   logic [1:0]         s1_mode_ff;
   logic [30:0]        s1_rad_ff;
   logic signed [31:0] a_v [3];
   logic signed [31:0] b_v [3];
   logic               neg_n [3];
   logic               is_box;

   always_comb begin
      a_v[0]   = req_payload.point_a_x;
      a_v[1]   = req_payload.point_a_y;
      a_v[2]   = req_payload.point_a_z;
      b_v[0]   = req_payload.point_b_x;
      b_v[1]   = req_payload.point_b_y;
      b_v[2]   = req_payload.point_b_z;
      neg_n[0] = nx_ff[31];
      neg_n[1] = ny_ff[31];
      neg_n[2] = nz_ff[31];
      is_box   = (req_payload.mode == psd_pkg::MODE_BOX);
      for (int i = 0; i < 3; i++) begin
         // swap near and far where the normal points toward minus
         if (is_box && neg_n[i]) begin
            s1_p_in[i] = b_v[i];
            s1_q_in[i] = a_v[i];
         end else begin
            s1_p_in[i] = a_v[i];
            s1_q_in[i] = b_v[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_p_ff    <= s1_p_in;
         s1_q_ff    <= s1_q_in;
         s1_mode_ff <= req_payload.mode;
         s1_rad_ff  <= req_payload.radius;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: six 32x32 products, each floored by FRAC_BITS. An
   // arithmetic shift of a signed value rounds toward minus infinity.
   // ------------------------------------------------------------------
   logic signed [31:0] nrm [3];
   logic signed [63:0] s2_p_in [3];
   logic signed [63:0] s2_q_in [3];
   logic signed [63:0] s2_p_ff [3];
   logic signed [63:0] s2_q_ff [3];
   logic [1:0]         s2_mode_ff;
   logic [30:0]        s2_rad_ff;

   always_comb begin
      nrm[0] = nx_ff;
      nrm[1] = ny_ff;
      nrm[2] = nz_ff;
      for (int i = 0; i < 3; i++) begin
         s2_p_in[i] = (64'(nrm[i]) * 64'(s1_p_ff[i])) >>> psd_pkg::FRAC_BITS;
         s2_q_in[i] = (64'(nrm[i]) * 64'(s1_q_ff[i])) >>> psd_pkg::FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_p_ff    <= s2_p_in;
         s2_q_ff    <= s2_q_in;
         s2_mode_ff <= s1_mode_ff;
         s2_rad_ff  <= s1_rad_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: sum the terms. The first point gets the offset taken off;
   // the second stays a raw dot product, since segment and ray need it so.
   // ------------------------------------------------------------------
   logic signed [63:0] off_w;
   logic signed [63:0] s3_d_ff, s3_e_ff;
   logic [1:0]         s3_mode_ff;
   logic [30:0]        s3_rad_ff;

   assign off_w = 64'(off_ff);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_d_ff    <= s2_p_ff[0] + s2_p_ff[1] + s2_p_ff[2] - off_w;
         s3_e_ff    <= s2_q_ff[0] + s2_q_ff[1] + s2_q_ff[2];
         s3_mode_ff <= s2_mode_ff;
         s3_rad_ff  <= s2_rad_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: second distance per mode. Segment: far end d0 + e. Ray:
   // direction projection as is. Box: far corner distance. Sphere: the
   // centre distance with the radius taken off and added on.
   // ------------------------------------------------------------------
   logic signed [63:0] rad_w;
   logic signed [63:0] s4_t_in;
   logic signed [63:0] s4_d_ff, s4_t_ff, s4_dm_ff, s4_dp_ff;
   logic [1:0]         s4_mode_ff;

   assign rad_w = {33'd0, s3_rad_ff};

   always_comb begin
      case (s3_mode_ff)
         psd_pkg::MODE_SEGMENT: s4_t_in = s3_d_ff + s3_e_ff;
         psd_pkg::MODE_BOX:     s4_t_in = s3_e_ff - off_w;
         default:               s4_t_in = s3_e_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_d_ff    <= s3_d_ff;
         s4_t_ff    <= s4_t_in;
         s4_dm_ff   <= s3_d_ff - rad_w;
         s4_dp_ff   <= s3_d_ff + rad_w;
         s4_mode_ff <= s3_mode_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: choose the gap, zero where the shape meets the plane.
   // ------------------------------------------------------------------
   logic signed [63:0] s5_res_in, s5_res_ff;

   always_comb begin
      case (s4_mode_ff)
         psd_pkg::MODE_SEGMENT: begin
            if (s4_d_ff > 0) begin
               if (s4_t_ff > 0) s5_res_in = (s4_d_ff < s4_t_ff) ? s4_d_ff : s4_t_ff;
               else             s5_res_in = '0;
            end else begin
               if (s4_t_ff < 0) s5_res_in = (s4_d_ff > s4_t_ff) ? s4_d_ff : s4_t_ff;
               else             s5_res_in = '0;
            end
         end
         psd_pkg::MODE_RAY: begin
            if (s4_t_ff > 0) s5_res_in = (s4_d_ff < 0) ? 64'sd0 : s4_d_ff;
            else             s5_res_in = (s4_d_ff > 0) ? 64'sd0 : s4_d_ff;
         end
         psd_pkg::MODE_SPHERE: begin
            if (s4_dm_ff > 0)      s5_res_in = s4_dm_ff;
            else if (s4_dp_ff < 0) s5_res_in = s4_dp_ff;
            else                   s5_res_in = '0;
         end
         default: begin
            // box: near corner beyond the plane, else far corner short of it
            if (s4_d_ff > 0)       s5_res_in = s4_d_ff;
            else if (s4_t_ff >= 0) s5_res_in = '0;
            else                   s5_res_in = s4_t_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[4]) s5_res_ff <= s5_res_in;
   end

   // ------------------------------------------------------------------
   // Stage 6: side code from the full-width sign, then saturate.
   // ------------------------------------------------------------------
   logic signed [31:0] s6_dist_in, s6_dist_ff;
   psd_pkg::side_type  s6_side_in, s6_side_ff;

   always_comb begin
      if (s5_res_ff == 0)     s6_side_in = psd_pkg::SIDE_CROSS;
      else if (s5_res_ff[63]) s6_side_in = psd_pkg::SIDE_NEGATIVE;
      else                    s6_side_in = psd_pkg::SIDE_POSITIVE;

      if (s5_res_ff[63] && !(&s5_res_ff[62:31]))      s6_dist_in = 32'sh8000_0000;
      else if (!s5_res_ff[63] && (|s5_res_ff[62:31])) s6_dist_in = 32'sh7fff_ffff;
      else                                            s6_dist_in = s5_res_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_dist_ff <= s6_dist_in;
         s6_side_ff <= s6_side_in;
      end
   end

   assign rsp_valid            = vld_ff[psd_pkg::STAGES-1];
   assign rsp_payload.distance = s6_dist_ff;
   assign rsp_payload.side     = s6_side_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `PSD_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready, vld_ff[0],
      "accepted transaction did not reach stage 1")
   `PSD_ASSERT_IMPLY(a_side_zero, clock, reset, rsp_valid,
      (rsp_payload.side == psd_pkg::SIDE_CROSS) == (rsp_payload.distance == 0),
      "side code disagrees with a zero distance")
   `PSD_ASSERT_IMPLY(a_side_sign, clock, reset,
      rsp_valid && (rsp_payload.side != psd_pkg::SIDE_CROSS),
      (rsp_payload.side == psd_pkg::SIDE_NEGATIVE) == rsp_payload.distance[31],
      "side code disagrees with the distance sign")
   `PSD_ASSERT_NEXT(a_stall_holds, clock, reset, vld_ff[4] && !adv[4], vld_ff[4],
      "stalled stage 5 lost its transaction")

endmodule

// ----- tb/sv/plane_shape_signed_distance_tb.sv -----
// Self-checking testbench for the plane versus shape signed-distance block.
`timescale 1ns / 1ps

module plane_shape_signed_distance_tb;
   import psd_pkg::*;

   // Q16.16 one, and the signed 32-bit extremes
   localparam logic signed [31:0] ONE   = 32'sh0001_0000;
   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   localparam int PHASES          = 8;
   localparam int SHAPES_PER_SET  = 140;
   localparam int FIRST_UNIT_ROW  = 2;       // rows before this run on the reset plane
   localparam int PIPE_DRAIN      = STAGES + 4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRINT_CAP       = 40;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_type         req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_type         rsp_payload;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic            pready;

   plane_shape_signed_distance uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // 4 ns period
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Local copy of the plane, updated as each register write lands
   logic signed [31:0] plane_n [0:2];
   logic signed [31:0] plane_off;

   // Expected gaps, oldest first, one per accepted shape
   rsp_type pending_gaps [$];

   // Typed-in expectation for the directed row currently being driven
   bit              row_typed;
   logic [31:0]     row_dist;
   side_type        row_side;

   // When set, neither side idles
   bit steady;

   int mismatch_count;
   int shapes_accepted;
   int results_checked;
   int plane_settings;
   int idle_cycles;

   typedef struct {
      mode_type           mode;
      logic signed [31:0] ax;
      logic signed [31:0] bx;
      logic [30:0]        radius;
      bit                 typed;
      logic [31:0]        want_dist;
      side_type           side;
   } shape_row_type;

   shape_row_type shape_table [$];

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Dot of the normal with a point; each product floored back to Q16.16
   function automatic longint dot_normal(longint x, longint y, longint z);
      longint acc;
      acc = (longint'(plane_n[0]) * x) >>> FRAC_BITS;
      acc += (longint'(plane_n[1]) * y) >>> FRAC_BITS;
      acc += (longint'(plane_n[2]) * z) >>> FRAC_BITS;
      return acc;
   endfunction

   function automatic longint point_gap(longint x, longint y, longint z);
      return dot_normal(x, y, z) - longint'(plane_off);
   endfunction

   function automatic rsp_type predict_gap(req_type q);
      longint  ax, ay, az, bx, by, bz;
      longint  d0, d1, gap;
      rsp_type r;
      ax = longint'($signed(q.point_a_x));
      ay = longint'($signed(q.point_a_y));
      az = longint'($signed(q.point_a_z));
      bx = longint'($signed(q.point_b_x));
      by = longint'($signed(q.point_b_y));
      bz = longint'($signed(q.point_b_z));
      gap = 0;
      case (q.mode)
         MODE_SEGMENT: begin
            // far end distance is origin distance plus the direction term
            d0 = point_gap(ax, ay, az);
            d1 = d0 + dot_normal(bx, by, bz);
            if (d0 > 0) begin
               if (d1 > 0) gap = (d0 < d1) ? d0 : d1;
            end else begin
               if (d1 < 0) gap = (d0 > d1) ? d0 : d1;
            end
         end
         MODE_RAY: begin
            d0 = point_gap(ax, ay, az);
            d1 = dot_normal(bx, by, bz);
            if (d1 > 0) begin
               if (d0 >= 0) gap = d0;
            end else begin
               if (d0 <= 0) gap = d0;
            end
         end
         MODE_SPHERE: begin
            d0 = point_gap(ax, ay, az);
            d1 = longint'(q.radius);
            if (d0 > d1) gap = d0 - d1;
            else if (-d0 > d1) gap = d0 + d1;
         end
         default: begin
            // near corner takes the minimum where the normal is non-negative
            d0 = point_gap((plane_n[0] >= 0) ? ax : bx,
                           (plane_n[1] >= 0) ? ay : by,
                           (plane_n[2] >= 0) ? az : bz);
            if (d0 > 0) begin
               gap = d0;
            end else begin
               d1 = point_gap((plane_n[0] >= 0) ? bx : ax,
                              (plane_n[1] >= 0) ? by : ay,
                              (plane_n[2] >= 0) ? bz : az);
               if (d1 < 0) gap = d1;
            end
         end
      endcase
      // side follows the unsaturated sign
      if (gap == 0) r.side = SIDE_CROSS;
      else if (gap > 0) r.side = SIDE_POSITIVE;
      else r.side = SIDE_NEGATIVE;
      if (gap > SAT_HI) gap = SAT_HI;
      if (gap < SAT_LO) gap = SAT_LO;
      r.distance = gap[31:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned k;
      if (steady) return 0;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 90) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [31:0] pick_coord();
      int unsigned k;
      k = $urandom_range(0, 9);
      case (k)
         0: begin
            case ($urandom_range(0, 4))
               0:       return S_MAX;
               1:       return S_MIN;
               2:       return 32'sd0;
               3:       return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1, 2, 3, 4: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
         default:    return $urandom;
      endcase
   endfunction

   function automatic req_type random_shape();
      req_type            s;
      logic signed [31:0] t;
      longint             d;
      int unsigned        k;
      s.mode      = 2'($urandom_range(0, 3));
      s.point_a_x = pick_coord();
      s.point_a_y = pick_coord();
      s.point_a_z = pick_coord();
      s.point_b_x = pick_coord();
      s.point_b_y = pick_coord();
      s.point_b_z = pick_coord();
      s.radius    = 31'($urandom);
      if (s.mode == MODE_SPHERE) begin
         k = $urandom_range(0, 9);
         if (k < 4) begin
            // put the surface on the plane, or one step short of it
            d = point_gap(longint'($signed(s.point_a_x)), longint'($signed(s.point_a_y)),
                          longint'($signed(s.point_a_z)));
            if (d < 0) d = -d;
            if (k == 3) d = d - 1;
            if (d >= 0 && d <= SAT_HI) s.radius = d[30:0];
         end else if (k < 7) begin
            s.radius = 31'($urandom_range(0, 32'h0008_0000));
         end else if (k == 7) begin
            s.radius = '1;
         end else if (k == 8) begin
            s.radius = '0;
         end
      end else if (s.mode == MODE_BOX && $urandom_range(0, 9) < 7) begin
         // order the corners; the rest stay as drawn, inverted boxes included
         if (s.point_a_x > s.point_b_x) begin
            t = s.point_a_x; s.point_a_x = s.point_b_x; s.point_b_x = t;
         end
         if (s.point_a_y > s.point_b_y) begin
            t = s.point_a_y; s.point_a_y = s.point_b_y; s.point_b_y = t;
         end
         if (s.point_a_z > s.point_b_z) begin
            t = s.point_a_z; s.point_a_z = s.point_b_z; s.point_b_z = t;
         end
      end
      return s;
   endfunction

   function automatic shape_row_type mk_row(mode_type m, logic signed [31:0] ax,
                                            logic signed [31:0] bx, logic [30:0] rad,
                                            bit typed, logic [31:0] want_dist,
                                            side_type sd);
      shape_row_type r;
      r.mode      = m;
      r.ax        = ax;
      r.bx        = bx;
      r.radius    = rad;
      r.typed     = typed;
      r.want_dist = want_dist;
      r.side      = sd;
      return r;
   endfunction

   // Drive one shape after a gap; returns at the edge where it is accepted
   task automatic send_shape(input req_type item, input int gap, input bit typed,
                             input logic [31:0] want_dist, input side_type sd);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      row_typed = typed;
      row_dist  = want_dist;
      row_side  = sd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic write_plane_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == REG_PLANE_OFFSET) plane_off = value;
      else plane_n[idx] = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_plane_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== value) report_mismatch("register read-back", got, value);
   endtask

   // Let the pipe empty, then load and read back all four plane registers
   task automatic set_plane(input logic [31:0] nx, input logic [31:0] ny,
                            input logic [31:0] nz, input logic [31:0] off);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_gaps.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      write_plane_reg(REG_NORMAL_X, nx);
      write_plane_reg(REG_NORMAL_Y, ny);
      write_plane_reg(REG_NORMAL_Z, nz);
      write_plane_reg(REG_PLANE_OFFSET, off);
      check_plane_reg(REG_NORMAL_X, nx);
      check_plane_reg(REG_NORMAL_Y, ny);
      check_plane_reg(REG_NORMAL_Z, nz);
      check_plane_reg(REG_PLANE_OFFSET, off);
      plane_settings++;
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure, with stall-free stretches
   // ------------------------------------------------------------------
   initial begin : rsp_sink
      int hold;
      rsp_ready = 1'b0;
      forever begin
         hold = pick_gap();
         repeat (hold) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         hold = $urandom_range(1, 12);
         repeat (hold) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Scoreboard: predict on acceptance, compare on each result, watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      bit      moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            want = predict_gap(req_payload);
            // directed rows may carry the value straight from the table
            if (row_typed) begin
               want.distance = row_dist;
               want.side     = row_side;
            end
            pending_gaps.push_back(want);
            shapes_accepted++;
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (pending_gaps.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_payload.distance, '0);
            end else begin
               want = pending_gaps.pop_front();
               if (rsp_payload.distance !== want.distance)
                  report_mismatch("distance", rsp_payload.distance, want.distance);
               if (rsp_payload.side !== want.side)
                  report_mismatch("side", 32'(rsp_payload.side), 32'(want.side));
               results_checked++;
            end
         end
         if (psel && penable && pready) moved = 1'b1;
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transaction, %0d results outstanding",
                     idle_cycles, pending_gaps.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      req_type            item;
      logic signed [31:0] nx, ny, nz, off;
      int                 ph;
      int                 i;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      row_typed   = 1'b0;
      row_dist    = '0;
      row_side    = SIDE_CROSS;
      steady      = 1'b0;
      plane_n[0]  = '0;
      plane_n[1]  = '0;
      plane_n[2]  = '0;
      plane_off   = '0;
      mismatch_count  = 0;
      shapes_accepted = 0;
      results_checked = 0;
      plane_settings  = 0;
      idle_cycles     = 0;

      // Zero plane after reset: every distance is zero
      shape_table.push_back(mk_row(MODE_SEGMENT, S_MAX, S_MIN, '0, 1, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_SPHERE, S_MIN, S_MAX, '0, 1, '0, SIDE_CROSS));
      // Unit normal along x, zero offset: distance is the x coordinate
      shape_table.push_back(mk_row(MODE_SEGMENT, 5*ONE, 2*ONE, '0, 1, 5*ONE, SIDE_POSITIVE));
      shape_table.push_back(mk_row(MODE_SEGMENT, 5*ONE, -7*ONE, '0, 1, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_SEGMENT, -3*ONE, -ONE, '0, 1, -3*ONE, SIDE_NEGATIVE));
      shape_table.push_back(mk_row(MODE_SEGMENT, -3*ONE, 3*ONE, '0, 1, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_SEGMENT, S_MIN, S_MIN, '0, 1, S_MIN, SIDE_NEGATIVE));
      shape_table.push_back(mk_row(MODE_RAY, 4*ONE, ONE, '0, 1, 4*ONE, SIDE_POSITIVE));
      shape_table.push_back(mk_row(MODE_RAY, -4*ONE, ONE, '0, 1, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_RAY, 4*ONE, '0, '0, 1, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_RAY, -4*ONE, -ONE, '0, 1, -4*ONE, SIDE_NEGATIVE));
      shape_table.push_back(mk_row(MODE_RAY, S_MAX, 32'sd1, '0, 1, S_MAX, SIDE_POSITIVE));
      shape_table.push_back(mk_row(MODE_RAY, 32'sh0000_8001, -32'sd1, '0, 0, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_SPHERE, 10*ONE, '0, 31'(3*ONE), 1, 7*ONE,
                                   SIDE_POSITIVE));
      shape_table.push_back(mk_row(MODE_SPHERE, -10*ONE, '0, 31'(3*ONE), 1, -7*ONE,
                                   SIDE_NEGATIVE));
      shape_table.push_back(mk_row(MODE_SPHERE, 3*ONE, '0, 31'(3*ONE), 1, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_SPHERE, S_MAX, S_MIN, '1, 1, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_SPHERE, S_MIN, S_MAX, '0, 1, S_MIN, SIDE_NEGATIVE));
      shape_table.push_back(mk_row(MODE_BOX, 2*ONE, 5*ONE, '0, 1, 2*ONE, SIDE_POSITIVE));
      shape_table.push_back(mk_row(MODE_BOX, -5*ONE, -2*ONE, '0, 1, -2*ONE, SIDE_NEGATIVE));
      shape_table.push_back(mk_row(MODE_BOX, -ONE, ONE, '0, 1, '0, SIDE_CROSS));
      // inverted box is evaluated by the same corner rule
      shape_table.push_back(mk_row(MODE_BOX, 5*ONE, 2*ONE, '0, 1, 5*ONE, SIDE_POSITIVE));
      shape_table.push_back(mk_row(MODE_BOX, S_MIN, S_MAX, '0, 1, '0, SIDE_CROSS));
      shape_table.push_back(mk_row(MODE_BOX, -32'sd1, 32'sh0000_7FFF, '0, 0, '0, SIDE_CROSS));

      // Hold reset, then release it on a falling edge
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table; y and z carry extremes the unit plane ignores
      for (i = 0; i < shape_table.size(); i++) begin
         if (i == FIRST_UNIT_ROW) set_plane(ONE, '0, '0, '0);
         item.mode      = shape_table[i].mode;
         item.point_a_x = shape_table[i].ax;
         item.point_b_x = shape_table[i].bx;
         item.point_a_y = (i % 2) ? S_MAX : S_MIN;
         item.point_a_z = (i % 2) ? S_MIN : S_MAX;
         item.point_b_y = (i % 2) ? S_MIN : S_MAX;
         item.point_b_z = (i % 2) ? S_MAX : S_MIN;
         item.radius    = shape_table[i].radius;
         send_shape(item, pick_gap(), shape_table[i].typed, shape_table[i].want_dist,
                    shape_table[i].side);
      end

      // Random part: one plane per phase, extremes included
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            1: begin
               nx = S_MAX; ny = S_MAX; nz = S_MAX; off = S_MIN;
            end
            2: begin
               nx = S_MIN; ny = S_MIN; nz = S_MIN; off = S_MAX;
            end
            3, 7: begin
               nx  = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
               ny  = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
               nz  = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
               off = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
            end
            4: begin
               // tiny raw normals make the floor of each product matter
               nx  = 32'($urandom_range(0, 8)) - 32'd4;
               ny  = 32'($urandom_range(0, 8)) - 32'd4;
               nz  = 32'($urandom_range(0, 8)) - 32'd4;
               off = '0;
            end
            5: begin
               nx = '0; ny = '0; nz = '0; off = $urandom;
            end
            default: begin
               nx = $urandom; ny = $urandom; nz = $urandom; off = $urandom;
            end
         endcase
         set_plane(nx, ny, nz, off);
         steady = (ph == 3 || ph == 6);
         for (i = 0; i < SHAPES_PER_SET; i++)
            send_shape(random_shape(), pick_gap(), 1'b0, '0, SIDE_CROSS);
         steady = 1'b0;
      end

      // Drop valid, let every result arrive, then watch a quiet pipe
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_gaps.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);

      $display("covered %0d shapes in all four modes over %0d plane settings",
               shapes_accepted, plane_settings);
      $display("checked %0d results and all register read-backs", results_checked);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
